// ===== rtl/flvd_pkg.sv =====
// ----------------------------------------------------------------------------
// flvd_pkg
// shared types and constants of the flv tag deframer: parse phases,
// field lengths and the tag type codes that are passed on
// ----------------------------------------------------------------------------
package flvd_pkg;

    // parse phase of the byte stream
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_TIME    = 3'd3,
        PH_SKIP    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_TRAILER = 3'd6
    } phase_t;

    localparam int unsigned CNT_W = 4;

    // file header plus first previous-tag-size
    localparam logic [CNT_W-1:0] FILE_HEAD_BYTES = 4'd13;
    // 24-bit big-endian fields
    localparam logic [CNT_W-1:0] FIELD24_BYTES   = 4'd3;
    // extension byte plus stream id
    localparam logic [CNT_W-1:0] SKIP_BYTES      = 4'd4;
    // previous-tag-size after each tag
    localparam logic [CNT_W-1:0] TRAILER_BYTES   = 4'd4;

    localparam logic [7:0] KIND_AUDIO = 8'h08;
    localparam logic [7:0] KIND_VIDEO = 8'h09;

endpackage

// ===== rtl/flv_tag_deframer.sv =====
// ----------------------------------------------------------------------------
// flv_tag_deframer
// splits an flv byte stream into audio and video payload bytes, each marked
// with its tag kind, timestamp and a last-of-tag flag
// ----------------------------------------------------------------------------
// usage:
//   input channel: one stream byte per request on stream_byte, with
//   in_valid / in_stall. the first 13 bytes are dropped, then each tag
//   header (type, length, timestamp, extension, stream id) is parsed.
//   output channel: out_valid / out_stall with tag_kind, tag_time,
//   payload_byte, byte_present and tag_end. audio and video payload bytes
//   come out one per request; an empty audio or video tag gives a single
//   request with byte_present low and tag_end high. other tags, headers
//   and trailers give nothing.
//   path: a byte is captured in the input register and parsed
//   combinationally; its result is loaded into the output register once
//   the parse stage advances, which a held result can delay.
//   throughput: one byte per cycle while the output is free; the parser
//   state updates once per accepted byte.
//   reset: parsing restarts at the file header, both registers empty.
//   stall: a held result blocks the parse stage; the input register then
//   holds its byte and in_stall rises, so at most two bytes are in flight.
// ----------------------------------------------------------------------------
module flv_tag_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tag_kind,
    output logic [23:0] tag_time,
    output logic [7:0]  payload_byte,
    output logic        byte_present,
    output logic        tag_end
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parser state
    flvd_pkg::phase_t               phase_reg, phase_next;
    logic [flvd_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [7:0]                     type_reg, type_next;
    logic [23:0]                    len_reg, len_next;
    logic [23:0]                    time_reg, time_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [23:0] otime_reg, otime_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        present_reg, present_next;
    logic        end_reg, end_next;

    logic                         advance;
    logic                         kept;
    logic [flvd_pkg::CNT_W-1:0]   cnt_inc;
    logic                         emit;

    // parse stage moves when the result register is empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    assign kept    = (type_reg == flvd_pkg::KIND_AUDIO) || (type_reg == flvd_pkg::KIND_VIDEO);
    assign cnt_inc = cnt_reg + 1'b1;

    // input register: loads whenever it is not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= stream_byte;
        end
    end

    // parser: next state and result for the byte in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        time_next    = time_reg;
        emit         = 1'b0;
        obyte_next   = in_byte_reg;
        present_next = 1'b1;
        end_next     = 1'b0;

        case (phase_reg)
            flvd_pkg::PH_HEADER:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= flvd_pkg::FILE_HEAD_BYTES)
                begin
                    phase_next = flvd_pkg::PH_TYPE;
                    cnt_next   = '0;
                end
            end
            flvd_pkg::PH_LEN:
            begin
                len_next = {len_reg[15:0], in_byte_reg};
                cnt_next = cnt_inc;
                if (cnt_inc >= flvd_pkg::FIELD24_BYTES)
                begin
                    phase_next = flvd_pkg::PH_TIME;
                    cnt_next   = '0;
                end
            end
            flvd_pkg::PH_TIME:
            begin
                time_next = {time_reg[15:0], in_byte_reg};
                cnt_next  = cnt_inc;
                if (cnt_inc >= flvd_pkg::FIELD24_BYTES)
                begin
                    phase_next = flvd_pkg::PH_SKIP;
                    cnt_next   = '0;
                end
            end
            flvd_pkg::PH_SKIP:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= flvd_pkg::SKIP_BYTES)
                begin
                    cnt_next = '0;
                    if (len_reg == '0)
                    begin
                        // empty tag: marker only for audio and video
                        emit         = kept;
                        obyte_next   = '0;
                        present_next = 1'b0;
                        end_next     = 1'b1;
                        phase_next   = flvd_pkg::PH_TRAILER;
                    end
                    else
                    begin
                        phase_next = flvd_pkg::PH_PAYLOAD;
                    end
                end
            end
            flvd_pkg::PH_PAYLOAD:
            begin
                emit     = kept;
                end_next = (len_reg <= 24'd1);
                if (len_reg != '0)
                begin
                    len_next = len_reg - 24'd1;
                end
                if (len_reg <= 24'd1)
                begin
                    phase_next = flvd_pkg::PH_TRAILER;
                    cnt_next   = '0;
                end
            end
            flvd_pkg::PH_TRAILER:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= flvd_pkg::TRAILER_BYTES)
                begin
                    phase_next = flvd_pkg::PH_TYPE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                // type byte, also taken for the unused code
                type_next  = in_byte_reg;
                len_next   = '0;
                time_next  = '0;
                cnt_next   = '0;
                phase_next = flvd_pkg::PH_LEN;
            end
        endcase

        kind_next  = (type_reg == flvd_pkg::KIND_VIDEO);
        otime_next = time_reg;

        // result register empties when taken and refills from the parse stage
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= flvd_pkg::PH_HEADER;
            cnt_reg       <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_valid_reg && advance)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                type_reg  <= type_next;
                len_reg   <= len_next;
                time_reg  <= time_next;
            end
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance && emit)
        begin
            kind_reg    <= kind_next;
            otime_reg   <= otime_next;
            obyte_reg   <= obyte_next;
            present_reg <= present_next;
            end_reg     <= end_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tag_kind     = kind_reg;
    assign tag_time     = otime_reg;
    assign payload_byte = obyte_reg;
    assign byte_present = present_reg;
    assign tag_end      = end_reg;

`ifndef ASSERT_OFF
    // an empty-tag marker always closes its tag
    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_present |-> tag_end)
        else $error("empty-tag marker without tag_end");

    // the input only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled without a held result");

    // payload phase always has bytes left to consume
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == flvd_pkg::PH_PAYLOAD |-> len_reg != '0)
        else $error("payload phase with zero length");
`endif

endmodule

// ===== bench/flvd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvd_checker
// watches both channels of the flv tag deframer, predicts the payload
// requests from the accepted stream bytes and compares them field by field
// ----------------------------------------------------------------------------
module flvd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  stream_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        tag_kind,
    input  logic [23:0] tag_time,
    input  logic [7:0]  payload_byte,
    input  logic        byte_present,
    input  logic        tag_end,
    output int unsigned mismatch_count,
    output int unsigned awaited,
    output int unsigned bytes_seen,
    output int unsigned payload_seen,
    output int unsigned markers_seen
);

    typedef struct packed {
        logic        kind;
        logic [23:0] stamp;
        logic [7:0]  data;
        logic        present;
        logic        last;
    } tag_result_t;

    tag_result_t      tag_bytes_due[$];

    // predicted parser state
    flvd_pkg::phase_t           phase;
    logic [flvd_pkg::CNT_W-1:0] field_cnt;
    logic [7:0]                 cur_type;
    logic [23:0]                left_len;
    logic [23:0]                cur_stamp;

    int unsigned      errs;
    int unsigned      n_bytes;
    int unsigned      n_payload;
    int unsigned      n_markers;

    function automatic tag_result_t tag_result(input logic [7:0] data, input logic present,
                                               input logic last);
        tag_result_t r;
        r.kind    = (cur_type == flvd_pkg::KIND_VIDEO);
        r.stamp   = cur_stamp;
        r.data    = data;
        r.present = present;
        r.last    = last;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        logic kept;
        kept = (cur_type == flvd_pkg::KIND_AUDIO) || (cur_type == flvd_pkg::KIND_VIDEO);
        case (phase)
            flvd_pkg::PH_HEADER:
            begin
                field_cnt = field_cnt + 1'b1;
                if (field_cnt >= flvd_pkg::FILE_HEAD_BYTES)
                begin
                    phase     = flvd_pkg::PH_TYPE;
                    field_cnt = '0;
                end
            end
            flvd_pkg::PH_LEN:
            begin
                left_len  = {left_len[15:0], b};
                field_cnt = field_cnt + 1'b1;
                if (field_cnt >= flvd_pkg::FIELD24_BYTES)
                begin
                    phase     = flvd_pkg::PH_TIME;
                    field_cnt = '0;
                end
            end
            flvd_pkg::PH_TIME:
            begin
                cur_stamp = {cur_stamp[15:0], b};
                field_cnt = field_cnt + 1'b1;
                if (field_cnt >= flvd_pkg::FIELD24_BYTES)
                begin
                    phase     = flvd_pkg::PH_SKIP;
                    field_cnt = '0;
                end
            end
            flvd_pkg::PH_SKIP:
            begin
                field_cnt = field_cnt + 1'b1;
                if (field_cnt >= flvd_pkg::SKIP_BYTES)
                begin
                    field_cnt = '0;
                    if (left_len == '0)
                    begin
                        // empty tag: a lone marker for audio and video
                        if (kept)
                            tag_bytes_due.push_back(tag_result(8'h00, 1'b0, 1'b1));
                        phase = flvd_pkg::PH_TRAILER;
                    end
                    else
                        phase = flvd_pkg::PH_PAYLOAD;
                end
            end
            flvd_pkg::PH_PAYLOAD:
            begin
                if (kept)
                    tag_bytes_due.push_back(tag_result(b, 1'b1, left_len <= 24'd1));
                if (left_len != '0)
                    left_len = left_len - 1'b1;
                if (left_len == '0)
                begin
                    phase     = flvd_pkg::PH_TRAILER;
                    field_cnt = '0;
                end
            end
            flvd_pkg::PH_TRAILER:
            begin
                field_cnt = field_cnt + 1'b1;
                if (field_cnt >= flvd_pkg::TRAILER_BYTES)
                begin
                    phase     = flvd_pkg::PH_TYPE;
                    field_cnt = '0;
                end
            end
            default:
            begin
                cur_type  = b;
                left_len  = '0;
                cur_stamp = '0;
                field_cnt = '0;
                phase     = flvd_pkg::PH_LEN;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tag_result_t want;
        if (!rst_n)
        begin
            phase     = flvd_pkg::PH_HEADER;
            field_cnt = '0;
            cur_type  = '0;
            left_len  = '0;
            cur_stamp = '0;
            tag_bytes_due.delete();
            errs      = 0;
            n_bytes   = 0;
            n_payload = 0;
            n_markers = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (byte_present)
                    n_payload++;
                else
                    n_markers++;
                if (tag_bytes_due.size() == 0)
                begin
                    $error("unexpected result: kind %0d time %h byte %h present %0d end %0d",
                           tag_kind, tag_time, payload_byte, byte_present, tag_end);
                    errs++;
                end
                else
                begin
                    want = tag_bytes_due.pop_front();
                    if (tag_kind !== want.kind)
                    begin
                        $error("tag_kind: expected %0d, actual %0d", want.kind, tag_kind);
                        errs++;
                    end
                    if (tag_time !== want.stamp)
                    begin
                        $error("tag_time: expected %h, actual %h", want.stamp, tag_time);
                        errs++;
                    end
                    if (payload_byte !== want.data)
                    begin
                        $error("payload_byte: expected %h, actual %h", want.data, payload_byte);
                        errs++;
                    end
                    if (byte_present !== want.present)
                    begin
                        $error("byte_present: expected %0d, actual %0d",
                               want.present, byte_present);
                        errs++;
                    end
                    if (tag_end !== want.last)
                    begin
                        $error("tag_end: expected %0d, actual %0d", want.last, tag_end);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                n_bytes++;
                deframe_byte(stream_byte);
            end
        end
        mismatch_count <= errs;
        awaited        <= tag_bytes_due.size();
        bytes_seen     <= n_bytes;
        payload_seen   <= n_payload;
        markers_seen   <= n_markers;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the flv tag deframer: a directed stream of corner
// tags, then random tags with random gaps and output stalls; a checker beside
// the block predicts and compares every payload request
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_BYTES = 1250;
    // two register stages from acceptance to out_valid, plus margin
    localparam int unsigned DRAIN_CYCLES = 8;
    // some tag type that is neither audio nor video (script data)
    localparam logic [7:0] KIND_SCRIPT = 8'h12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  stream_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        tag_kind;
    logic [23:0] tag_time;
    logic [7:0]  payload_byte;
    logic        byte_present;
    logic        tag_end;

    int unsigned mismatch_count;
    int unsigned awaited;
    int unsigned bytes_seen;
    int unsigned payload_seen;
    int unsigned markers_seen;

    // whole byte stream, built up front and then fed out
    logic [7:0]  stream_q[$];
    int unsigned tags_built = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    flv_tag_deframer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tag_kind     (tag_kind),
        .tag_time     (tag_time),
        .payload_byte (payload_byte),
        .byte_present (byte_present),
        .tag_end      (tag_end)
    );

    flvd_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tag_kind       (tag_kind),
        .tag_time       (tag_time),
        .payload_byte   (payload_byte),
        .byte_present   (byte_present),
        .tag_end        (tag_end),
        .mismatch_count (mismatch_count),
        .awaited        (awaited),
        .bytes_seen     (bytes_seen),
        .payload_seen   (payload_seen),
        .markers_seen   (markers_seen)
    );

    // appends one complete tag: header, payload and previous-tag-size trailer
    // fill below zero means random payload bytes, otherwise a constant byte
    task automatic put_tag(input logic [7:0] kind, input logic [23:0] len,
                           input logic [23:0] stamp, input int fill);
        logic [31:0] tag_size;
        logic [31:0] trailer;
        tag_size = 32'd11 + len;
        // a fifth of the trailers and stream ids carry junk, which must be ignored
        trailer = ($urandom_range(0, 4) == 0) ? $urandom : tag_size;
        stream_q.push_back(kind);
        stream_q.push_back(len[23:16]);
        stream_q.push_back(len[15:8]);
        stream_q.push_back(len[7:0]);
        stream_q.push_back(stamp[23:16]);
        stream_q.push_back(stamp[15:8]);
        stream_q.push_back(stamp[7:0]);
        // extension byte, then the 3-byte stream id
        stream_q.push_back(8'($urandom));
        for (int i = 0; i < 3; i++)
            stream_q.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00);
        for (int i = 0; i < int'(len); i++)
            stream_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        stream_q.push_back(trailer[31:24]);
        stream_q.push_back(trailer[23:16]);
        stream_q.push_back(trailer[15:8]);
        stream_q.push_back(trailer[7:0]);
        tags_built++;
    endtask

    // directed corner tags after the file header
    task automatic build_directed();
        logic [7:0] file_head[13];
        file_head = '{8'h46, 8'h4c, 8'h56, 8'h01, 8'h05, 8'h00, 8'h00, 8'h00,
                      8'h09, 8'h00, 8'h00, 8'h00, 8'h00};
        foreach (file_head[i])
            stream_q.push_back(file_head[i]);
        // empty video tag at the largest timestamp: marker only
        put_tag(flvd_pkg::KIND_VIDEO, 24'd0, 24'hff_ffff, -1);
        // single-byte audio tag at time zero, all-ones payload
        put_tag(flvd_pkg::KIND_AUDIO, 24'd1, 24'h00_0000, 8'hff);
        // empty tag of another type: nothing, trailer follows at once
        put_tag(KIND_SCRIPT, 24'd0, 24'h12_3456, -1);
        // non-empty tag of another type: payload swallowed
        put_tag(KIND_SCRIPT, 24'd2, 24'h00_0001, -1);
        // short video tag whose three payload bytes are all zero
        put_tag(flvd_pkg::KIND_VIDEO, 24'd3, 24'ha5_5a5a, 8'h00);
    endtask

    task automatic build_random();
        int unsigned stop_at;
        int unsigned pick;
        logic [7:0]  kind;
        logic [23:0] len;
        stop_at = stream_q.size() + RANDOM_BYTES;
        while (stream_q.size() < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                kind = flvd_pkg::KIND_AUDIO;
            else if (pick < 90)
                kind = flvd_pkg::KIND_VIDEO;
            else
                kind = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 15)
                len = 24'd0;
            else if (pick < 80)
                len = 24'($urandom_range(1, 8));
            else if (pick < 97)
                len = 24'($urandom_range(9, 60));
            else
                len = 24'($urandom_range(256, 300));
            put_tag(kind, len, 24'($urandom), -1);
        end
    endtask

    // output back-pressure: alternating stall and free spells, mostly short
    initial
    begin
        int unsigned pick;
        @(posedge rst_n);
        forever
        begin
            pick = $urandom_range(0, 99);
            out_stall <= 1'b1;
            if (pick < 70)
                repeat ($urandom_range(1, 2)) @(posedge clk);
            else if (pick < 95)
                repeat ($urandom_range(3, 6)) @(posedge clk);
            else
                repeat ($urandom_range(15, 40)) @(posedge clk);
            pick = $urandom_range(0, 99);
            out_stall <= 1'b0;
            if (pick < 80)
                repeat ($urandom_range(1, 6)) @(posedge clk);
            else
                repeat ($urandom_range(30, 120)) @(posedge clk);
        end
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned calm_left;
        int unsigned pick;
        int unsigned gap;
        build_directed();
        build_random();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm_left = 0;
        while (stream_q.size() != 0)
        begin
            stream_byte <= stream_q.pop_front();
            in_valid    <= 1'b1;
            // hold the request until the block takes it
            do
                @(posedge clk);
            while (in_stall);

            // pick the idle time before the next request
            gap = 0;
            if (calm_left != 0)
                calm_left--;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    calm_left = $urandom_range(20, 80);
                else if (pick < 65)
                    gap = 0;
                else if (pick < 93)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(10, 30);
            end
            if (gap != 0 || stream_q.size() == 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        // let the checker see the last acceptance, then drain
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d stream bytes in %0d tags", bytes_seen, tags_built);
        $display("with %0d payload bytes and %0d empty-tag markers",
                 payload_seen, markers_seen);
        if (mismatch_count == 0 && awaited == 0 && !out_valid)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
